@@ rtl/rftn_pkg.sv @@
package rftn_pkg;

    localparam int ID_W    = 8;
    localparam int FINGERS = 8;
    localparam int IDX_W   = $clog2(FINGERS);
    localparam int CMD_W   = 3;

    localparam logic [CMD_W-1:0] CMD_ALONE_INIT = 3'd0;
    localparam logic [CMD_W-1:0] CMD_CLOSEST    = 3'd1;
    localparam logic [CMD_W-1:0] CMD_GET_SUCC   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_GET_PRED   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_SET_PRED   = 3'd4;
    localparam logic [CMD_W-1:0] CMD_LOAD       = 3'd5;
    localparam logic [CMD_W-1:0] CMD_UPD_JOIN   = 3'd6;
    localparam logic [CMD_W-1:0] CMD_UPD_LEAVE  = 3'd7;

    typedef logic [ID_W-1:0]  t_id;
    typedef logic [IDX_W-1:0] t_idx;
    typedef logic [CMD_W-1:0] t_cmd;

    // finger table port request
    typedef struct packed {
        logic rd_en;
        t_idx rd_addr;
        logic wr_en;
        t_idx wr_addr;
        t_id  wr_data;
    } t_ftab_req;

    // operands of the circular interval test
    typedef struct packed {
        t_id  lo;
        logic lo_incl;
        t_id  hi;
        logic hi_incl;
        t_id  x;
    } t_arc_op;

endpackage

@@ rtl/rftn_if.sv @@
interface rftn_req_if;
    logic             valid;
    logic             ready;
    rftn_pkg::t_cmd   command;
    rftn_pkg::t_id    target_id;
    rftn_pkg::t_idx   finger_index;
    rftn_pkg::t_id    leaving_id;

    modport source (output valid, command, target_id, finger_index, leaving_id,
                    input ready);
    modport sink   (input valid, command, target_id, finger_index, leaving_id,
                    output ready);
endinterface

interface rftn_rsp_if;
    logic             valid;
    logic             ready;
    rftn_pkg::t_id    result_id;
    logic             forward_update;
    rftn_pkg::t_id    forward_to;

    modport source (output valid, result_id, forward_update, forward_to,
                    input ready);
    modport sink   (input valid, result_id, forward_update, forward_to,
                    output ready);
endinterface

@@ rtl/rftn_arc.sv @@
module rftn_arc (
    input  rftn_pkg::t_arc_op i_op,
    output logic              o_inside
);

    logic above_lo;
    logic below_hi;

    assign above_lo = i_op.lo_incl ? (i_op.x >= i_op.lo) : (i_op.x > i_op.lo);
    assign below_hi = i_op.hi_incl ? (i_op.x <= i_op.hi) : (i_op.x < i_op.hi);

    always_comb begin
        priority if (i_op.lo == i_op.hi) begin
            // degenerate arc: full ring, minus the end point if both ends open
            o_inside = (i_op.lo_incl || i_op.hi_incl) ? 1'b1 : (i_op.x != i_op.lo);
        end else if (i_op.lo < i_op.hi) begin
            o_inside = above_lo && below_hi;
        end else begin
            o_inside = above_lo || below_hi;
        end
    end

endmodule

@@ rtl/rftn_ftab.sv @@
module rftn_ftab (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  rftn_pkg::t_ftab_req i_req,
    output rftn_pkg::t_id       o_rd_data
);

    rftn_pkg::t_id                 mem [rftn_pkg::FINGERS];
    logic [rftn_pkg::FINGERS-1:0]  r_vld;
    rftn_pkg::t_id                 r_rd_data;
    logic                          r_rd_hit;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            mem[i_req.wr_addr] <= i_req.wr_data;
        end
        if (i_req.rd_en) begin
            r_rd_data <= mem[i_req.rd_addr];
        end
    end

    // entries never written read as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_hit <= 1'b0;
        end else begin
            if (i_req.rd_en) begin
                r_rd_hit <= r_vld[i_req.rd_addr];
            end
            if (i_req.wr_en) begin
                r_vld[i_req.wr_addr] <= 1'b1;
            end
        end
    end

    assign o_rd_data = r_rd_hit ? r_rd_data : '0;

endmodule

@@ rtl/ring_finger_table_node.sv @@
// Channel  Dir  Payload
// i_req    in   command, target_id, finger_index, leaving_id
// o_rsp    out  result_id, forward_update, forward_to
// i_cfg    in   node_id (write enable + data, no read-back)
//
// One request at a time; i_req.ready is high only while idle.
// get/set_predecessor go from idle straight to the result; get_successor, load and
// updates pass through S_READ and S_EVAL (table read, then evaluate); alone_init stays
// in S_FILL, one finger written per cycle; closest_finger loops READ/EVAL per finger scanned.
// The result register holds until o_rsp.ready; no new request is taken meanwhile.
// Synchronous active-low reset clears node_id, predecessor and the table.
module ring_finger_table_node (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  rftn_pkg::t_id     i_cfg_wdata,
    rftn_req_if.sink          i_req,
    rftn_rsp_if.source        o_rsp
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_READ = 3'd1;
    localparam logic [2:0] S_EVAL = 3'd2;
    localparam logic [2:0] S_FILL = 3'd3;
    localparam logic [2:0] S_OUT  = 3'd4;

    logic [2:0]          r_state, n_state;
    rftn_pkg::t_idx      r_cnt, n_cnt;
    rftn_pkg::t_id       r_node, r_pred, n_pred;
    rftn_pkg::t_cmd      r_cmd;
    rftn_pkg::t_id       r_target, r_leaving;
    rftn_pkg::t_idx      r_index;
    rftn_pkg::t_id       r_res, n_res;
    logic                r_fwd, n_fwd;
    rftn_pkg::t_id       r_fwd_to, n_fwd_to;

    rftn_pkg::t_ftab_req ftab_req;
    rftn_pkg::t_id       finger;
    rftn_pkg::t_arc_op   arc_op;
    logic                arc_in;
    logic                req_acc;

    assign req_acc = i_req.valid && i_req.ready;

    rftn_ftab u_ftab (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (ftab_req),
        .o_rd_data (finger)
    );

    // shared interval unit: closest scan tests the finger, join tests the target
    always_comb begin
        if (r_cmd == rftn_pkg::CMD_UPD_JOIN) begin
            arc_op = '{lo: r_node, lo_incl: 1'b1, hi: finger, hi_incl: 1'b0, x: r_target};
        end else begin
            arc_op = '{lo: r_node, lo_incl: 1'b0, hi: r_target, hi_incl: 1'b0, x: finger};
        end
    end

    rftn_arc u_arc (
        .i_op     (arc_op),
        .o_inside (arc_in)
    );

    always_comb begin
        n_state  = r_state;
        n_cnt    = r_cnt;
        n_pred   = r_pred;
        n_res    = r_res;
        n_fwd    = r_fwd;
        n_fwd_to = r_fwd_to;
        ftab_req = '{rd_en: 1'b0, rd_addr: r_cnt, wr_en: 1'b0, wr_addr: r_cnt,
                     wr_data: r_node};
        unique case (r_state)
            S_IDLE: begin
                if (req_acc) begin
                    n_res    = i_req.target_id;
                    n_fwd    = 1'b0;
                    n_fwd_to = '0;
                    unique case (i_req.command)
                        rftn_pkg::CMD_ALONE_INIT: begin
                            n_cnt   = '0;
                            n_state = S_FILL;
                        end
                        rftn_pkg::CMD_CLOSEST: begin
                            n_cnt   = rftn_pkg::t_idx'(rftn_pkg::FINGERS - 1);
                            n_state = S_READ;
                        end
                        rftn_pkg::CMD_GET_SUCC: begin
                            n_cnt   = '0;
                            n_state = S_READ;
                        end
                        rftn_pkg::CMD_GET_PRED: begin
                            n_res   = r_pred;
                            n_state = S_OUT;
                        end
                        rftn_pkg::CMD_SET_PRED: begin
                            n_pred  = i_req.target_id;
                            n_state = S_OUT;
                        end
                        default: begin
                            // load and both updates address the indexed entry
                            n_cnt   = i_req.finger_index;
                            n_state = S_READ;
                        end
                    endcase
                end
            end
            S_READ: begin
                ftab_req.rd_en = 1'b1;
                n_state        = S_EVAL;
            end
            S_EVAL: begin
                n_state = S_OUT;
                unique case (r_cmd)
                    rftn_pkg::CMD_CLOSEST: begin
                        priority if (arc_in) begin
                            n_res = finger;
                        end else if (r_cnt == '0) begin
                            n_res = r_node;
                        end else begin
                            n_cnt   = r_cnt - 1'b1;
                            n_state = S_READ;
                        end
                    end
                    rftn_pkg::CMD_GET_SUCC: begin
                        n_res = finger;
                    end
                    rftn_pkg::CMD_LOAD: begin
                        ftab_req.wr_en   = 1'b1;
                        ftab_req.wr_data = r_target;
                    end
                    rftn_pkg::CMD_UPD_JOIN: begin
                        if (arc_in) begin
                            ftab_req.wr_en   = 1'b1;
                            ftab_req.wr_data = r_target;
                            if (r_pred != r_target) begin
                                n_fwd    = 1'b1;
                                n_fwd_to = r_pred;
                            end
                        end
                    end
                    rftn_pkg::CMD_UPD_LEAVE: begin
                        if (finger == r_leaving) begin
                            ftab_req.wr_en   = 1'b1;
                            ftab_req.wr_data = r_target;
                            if (r_pred != r_leaving) begin
                                n_fwd    = 1'b1;
                                n_fwd_to = r_pred;
                            end
                        end
                    end
                    default: begin
                    end
                endcase
            end
            S_FILL: begin
                ftab_req.wr_en = 1'b1;
                if (r_cnt == rftn_pkg::t_idx'(rftn_pkg::FINGERS - 1)) begin
                    n_pred  = r_node;
                    n_res   = r_node;
                    n_state = S_OUT;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_OUT: begin
                if (o_rsp.ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_node  <= '0;
            r_pred  <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_pred  <= n_pred;
            if (i_cfg_we) begin
                r_node <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (req_acc) begin
            r_cmd     <= i_req.command;
            r_target  <= i_req.target_id;
            r_index   <= i_req.finger_index;
            r_leaving <= i_req.leaving_id;
        end
        r_res    <= n_res;
        r_fwd    <= n_fwd;
        r_fwd_to <= n_fwd_to;
    end

    assign i_req.ready          = (r_state == S_IDLE);
    assign o_rsp.valid          = (r_state == S_OUT);
    assign o_rsp.result_id      = r_res;
    assign o_rsp.forward_update = r_fwd;
    assign o_rsp.forward_to     = r_fwd_to;

    // load and updates always address the entry named in the request
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EVAL && (r_cmd == rftn_pkg::CMD_UPD_JOIN ||
            r_cmd == rftn_pkg::CMD_UPD_LEAVE || r_cmd == rftn_pkg::CMD_LOAD))
        |-> (r_cnt == r_index))
        else $error("update addresses wrong finger");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid |-> !i_req.ready)
        else $error("request taken while result pending");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && !o_rsp.forward_update) |-> (o_rsp.forward_to == '0))
        else $error("forward_to set without forward");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.forward_update) |->
            (r_cmd == rftn_pkg::CMD_UPD_JOIN || r_cmd == rftn_pkg::CMD_UPD_LEAVE))
        else $error("forward from non-update command");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        req_acc |=> !i_req.ready)
        else $error("sequencer did not leave idle");

endmodule
